### hdl/rhc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared constants and types of the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

	localparam int HUE_FRAC_BITS = 4;

	localparam int CH_W   = 8;
	localparam int HUE_W  = 13;
	localparam int DEN_W  = 9;
	localparam int SPRD_W = 17;

	// rounded quotient 2N+D over 2D: hue stays below 2^(10+F)
	localparam int HUE_QW = 10 + HUE_FRAC_BITS;
	localparam int HUE_NW = 19 + HUE_FRAC_BITS;
	localparam int SAT_QW = 8;
	localparam int SAT_NW = 17;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;

	localparam logic [8:0] OFS_RED      = 9'd0;
	localparam logic [8:0] OFS_GREEN    = 9'd120;
	localparam logic [8:0] OFS_BLUE     = 9'd240;
	localparam logic [8:0] OFS_RED_WRAP = 9'd360;
	localparam logic [8:0] HUE_SECTOR   = 9'd60;
	localparam logic [8:0] SAT_FULL     = 9'd255;

	localparam logic [DEN_W-1:0] DEN_SAFE = DEN_W'(2);

	typedef struct packed {
		logic [HUE_NW-1:0] hue_num;
		logic [DEN_W-1:0]  hue_den;
		logic [SAT_NW-1:0] sat_num;
		logic [DEN_W-1:0]  sat_den;
		logic [CH_W-1:0]   bright;
	} div_req_t;

endpackage

### hdl/rhc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_front
// Finds max, min and spread of a pixel, picks the hue sector and forms the
// rounded numerators and denominators for the divider pipeline.
// ----------------------------------------------------------------------------
module rhc_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [rhc_pkg::CH_W-1:0] red,
	input  logic [rhc_pkg::CH_W-1:0] green,
	input  logic [rhc_pkg::CH_W-1:0] blue,
	output logic                  req_valid,
	output rhc_pkg::div_req_t     req,
	input  logic                  req_full
);
	import rhc_pkg::*;

	logic              valid_s1;
	div_req_t          req_s1;
	logic              load;
	logic [CH_W-1:0]   mx;
	logic [CH_W-1:0]   mn;
	logic [CH_W-1:0]   spread;
	logic signed [SPRD_W:0] diff;
	logic [8:0]        offset;
	logic [SPRD_W-1:0] off_spread;
	logic signed [SPRD_W:0] hue_sum;
	div_req_t          calc;

	always_comb begin
		mx = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		mn = red;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		spread = mx - mn;

		// blue wins ties for the max, then green
		if (mx == blue) begin
			diff   = $signed({10'd0, red}) - $signed({10'd0, green});
			offset = OFS_BLUE;
		end else if (mx == green) begin
			diff   = $signed({10'd0, blue}) - $signed({10'd0, red});
			offset = OFS_GREEN;
		end else begin
			diff   = $signed({10'd0, green}) - $signed({10'd0, blue});
			offset = (green >= blue) ? OFS_RED : OFS_RED_WRAP;
		end

		off_spread = SPRD_W'(offset) * SPRD_W'(spread);
		hue_sum = $signed({1'b0, off_spread}) + diff * $signed({9'd0, HUE_SECTOR});

		if (spread == '0) begin
			calc.hue_num = '0;
			calc.hue_den = DEN_SAFE;
		end else begin
			calc.hue_num = (HUE_NW'(hue_sum[SPRD_W-1:0]) << (HUE_FRAC_BITS + 1))
				+ HUE_NW'(spread);
			calc.hue_den = {spread, 1'b0};
		end

		if (mx == '0) begin
			calc.sat_num = '0;
			calc.sat_den = DEN_SAFE;
		end else begin
			calc.sat_num = ((SAT_NW'(spread) * SAT_NW'(SAT_FULL)) << 1) + SAT_NW'(mx);
			calc.sat_den = {mx, 1'b0};
		end
		calc.bright = mx;
	end

	assign load = !valid_s1 || !req_full;
	assign full = !load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (load && push) begin
			req_s1 <= calc;
		end
	end

	assign req_valid = valid_s1;
	assign req       = req_s1;

endmodule

### hdl/rhc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_queue
// Short request queue between the front and the divider pipeline.
// ----------------------------------------------------------------------------
module rhc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_valid,
	input  rhc_pkg::div_req_t wr_data,
	output logic              full,
	output logic              empty,
	output rhc_pkg::div_req_t rd_data,
	input  logic              rd_take
);
	import rhc_pkg::*;

	div_req_t            mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;
	logic                do_wr;
	logic                do_rd;

	assign full  = (count_q == (QUEUE_AW + 1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr_valid && !full;
	assign do_rd = rd_take && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_wr && !do_rd) count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

### hdl/rhc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_back
// Restoring divider pipeline, one hue quotient bit per stage, saturation bits
// alongside in the first SAT_QW stages; the last stage is the result register.
// ----------------------------------------------------------------------------
module rhc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_empty,
	input  rhc_pkg::div_req_t req,
	output logic              req_take,
	output logic              empty,
	input  logic              pop,
	output logic [rhc_pkg::HUE_W-1:0] hue,
	output logic [rhc_pkg::CH_W-1:0]  saturation,
	output logic [rhc_pkg::CH_W-1:0]  brightness
);
	import rhc_pkg::*;

	typedef struct packed {
		logic [HUE_NW-1:0] hue_rem;
		logic [DEN_W-1:0]  hue_den;
		logic [HUE_QW-1:0] hue_quo;
		logic [SAT_NW-1:0] sat_rem;
		logic [DEN_W-1:0]  sat_den;
		logic [SAT_QW-1:0] sat_quo;
		logic [CH_W-1:0]   bright;
	} stage_t;

	stage_t stage_s [HUE_QW+1];
	logic   valid_s [HUE_QW+1];
	logic   adv;

	// the whole pipeline holds while the result waits unread
	assign adv      = !valid_s[HUE_QW] || pop;
	assign req_take = adv && !req_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (adv) begin
			valid_s[0] <= !req_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			stage_s[0].hue_rem <= req.hue_num;
			stage_s[0].hue_den <= req.hue_den;
			stage_s[0].hue_quo <= '0;
			stage_s[0].sat_rem <= req.sat_num;
			stage_s[0].sat_den <= req.sat_den;
			stage_s[0].sat_quo <= '0;
			stage_s[0].bright  <= req.bright;
		end
	end

	for (genvar j = 0; j < HUE_QW; j++) begin : g_stage
		localparam int HB = HUE_QW - 1 - j;
		stage_t nxt;
		logic [HUE_NW-1:0] hue_sub;

		function automatic logic [SAT_NW-1:0] sat_sub(input logic [DEN_W-1:0] den);
			sat_sub = SAT_NW'(den) << (SAT_QW - 1 - (j % SAT_QW));
		endfunction

		always_comb begin
			nxt = stage_s[j];
			hue_sub = HUE_NW'(stage_s[j].hue_den) << HB;
			if (stage_s[j].hue_rem >= hue_sub) begin
				nxt.hue_rem     = stage_s[j].hue_rem - hue_sub;
				nxt.hue_quo[HB] = 1'b1;
			end
			if (j < SAT_QW) begin
				if (stage_s[j].sat_rem >= sat_sub(stage_s[j].sat_den)) begin
					nxt.sat_rem = stage_s[j].sat_rem - sat_sub(stage_s[j].sat_den);
					nxt.sat_quo[SAT_QW - 1 - (j % SAT_QW)] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[j+1] <= 1'b0;
			end else if (adv) begin
				valid_s[j+1] <= valid_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv && valid_s[j]) begin
				stage_s[j+1] <= nxt;
			end
		end
	end

	assign empty      = !valid_s[HUE_QW];
	assign hue        = HUE_W'(stage_s[HUE_QW].hue_quo);
	assign saturation = stage_s[HUE_QW].sat_quo;
	assign brightness = stage_s[HUE_QW].bright;

endmodule

### hdl/rgb_to_hsv_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// Path from request to result: the front register, the queue, the divider
//   input register and one divider stage per hue bit.
// Throughput: one pixel per cycle while pop is held; the divider pipeline
//   is fully pipelined, the four-entry queue absorbs output stalls.
// Reset: arst_n clears every valid flag and the queue pointers at once.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [rhc_pkg::CH_W-1:0]     red,
	input  logic [rhc_pkg::CH_W-1:0]     green,
	input  logic [rhc_pkg::CH_W-1:0]     blue,
	output logic                         empty,
	input  logic                         pop,
	output logic [rhc_pkg::HUE_W-1:0]    hue,
	output logic [rhc_pkg::CH_W-1:0]     saturation,
	output logic [rhc_pkg::CH_W-1:0]     brightness
);
	import rhc_pkg::*;

	logic     fr_valid;
	div_req_t fr_req;
	logic     q_full;
	logic     q_empty;
	div_req_t q_head;
	logic     q_take;

	rhc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.req_valid (fr_valid),
		.req       (fr_req),
		.req_full  (q_full)
	);

	rhc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fr_valid),
		.wr_data  (fr_req),
		.full     (q_full),
		.empty    (q_empty),
		.rd_data  (q_head),
		.rd_take  (q_take)
	);

	rhc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_empty  (q_empty),
		.req        (q_head),
		.req_take   (q_take),
		.empty      (empty),
		.pop        (pop),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness)
	);

endmodule

### hdl/rhc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
module rhc_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      push,
	input logic                      full,
	input logic [rhc_pkg::CH_W-1:0]  red,
	input logic [rhc_pkg::CH_W-1:0]  green,
	input logic [rhc_pkg::CH_W-1:0]  blue,
	input logic                      empty,
	input logic                      pop,
	input logic [rhc_pkg::HUE_W-1:0] hue,
	input logic [rhc_pkg::CH_W-1:0]  saturation,
	input logic [rhc_pkg::CH_W-1:0]  brightness
);
	import rhc_pkg::*;

	localparam int HUE_LIMIT = 360 << HUE_FRAC_BITS;

	// hold a waiting result until it is taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(hue) && $stable(saturation)
			&& $stable(brightness))
		else $error("result changed while waiting");

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && brightness == '0 |-> saturation == '0 && hue == '0)
		else $error("black pixel with nonzero hue or saturation");

	// zero saturation only comes from a grey pixel
	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && saturation == '0 |-> hue == '0)
		else $error("grey pixel with nonzero hue");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> HUE_FRAC_BITS > 4 || int'(hue) < HUE_LIMIT)
		else $error("hue beyond a full turn");

endmodule

bind rgb_to_hsv_converter rhc_checker u_rhc_checker (.*);
